// File: rtl/sabs_pkg.sv
package sabs_pkg;

  // Configuration register indexes.
  localparam logic [0:0] CFG_ITEM_COUNT = 1'd0;
  localparam logic [0:0] CFG_ASCENDING  = 1'd1;

  localparam int unsigned CFG_DATA_W = 9;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Match types.
  localparam logic [2:0] MT_LESS     = 3'd0;
  localparam logic [2:0] MT_LESS_EQ  = 3'd1;
  localparam logic [2:0] MT_EQUAL    = 3'd2;
  localparam logic [2:0] MT_GREATER_EQ = 3'd3;
  localparam logic [2:0] MT_GREATER  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_EXACT   = 2'd1;
  localparam logic [1:0] ST_GREATER = 2'd2;
  localparam logic [1:0] ST_LESS    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write one store entry
    logic start;    // latch a query and issue the first probe
    logic step;     // consume one probe result and issue the next
    logic capture;  // register the decided result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_open;  // search interval still holds more than the boundary
  } stat_t;

endpackage

// File: rtl/sabs_if.sv
interface sabs_req_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [7:0]                    load_index;
  logic signed [VALUE_WIDTH-1:0] element_value;
  logic signed [VALUE_WIDTH-1:0] query_key;
  logic [2:0]                    match_type;

  modport source (
    output valid, kind, load_index, element_value, query_key, match_type,
    input  ready
  );
  modport sink (
    input  valid, kind, load_index, element_value, query_key, match_type,
    output ready
  );
endinterface

interface sabs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] match_status;
  logic [7:0] match_index;

  modport source (
    output valid, match_status, match_index,
    input  ready
  );
  modport sink (
    input  valid, match_status, match_index,
    output ready
  );
endinterface

// File: rtl/sabs_ram.sv
module sabs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sabs_ctrl.sv
module sabs_ctrl
  import sabs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  input  logic  req_kind_i,
  input  logic  rsp_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  req_ready_o,
  output logic  rsp_valid_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept && req_kind_i == KIND_LOAD) begin
          cmd_o.load = 1'b1;
        end else if (accept) begin
          cmd_o.start = 1'b1;
          state_d = stat_i.range_open ? S_SEARCH : S_DECIDE;
        end
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (!stat_i.range_open) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // The result register is free once its item has been taken.
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.capture = 1'b1;
          rsp_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

// File: rtl/sabs_dp.sv
module sabs_dp
  import sabs_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o,
  input  logic [7:0]                    load_index_i,
  input  logic signed [VALUE_WIDTH-1:0] element_value_i,
  input  logic signed [VALUE_WIDTH-1:0] query_key_i,
  input  logic [2:0]                    match_type_i,
  input  logic [8:0]                    item_count_i,
  input  logic                          ascending_i,
  output logic [1:0]                    match_status_o,
  output logic [7:0]                    match_index_o
);

  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MW  = (CW > 9) ? CW : 9;
  localparam int unsigned IXW = ((CW + 2) > 9) ? (CW + 2) : 9;
  localparam logic signed [IXW-1:0] ONE_S = IXW'(1);

  // Search interval [lo, hi) around the partition point.
  logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, n_q;
  logic [CW:0]     mid_sum;
  logic            eq_q, eq_d;
  logic            asc_q;
  logic signed [VALUE_WIDTH-1:0] key_q;
  logic [2:0]      type_q;
  logic [1:0]      status_q;
  logic [7:0]      index_q;

  logic [CW-1:0]   n_start;
  logic            ram_we;
  logic [VALUE_WIDTH-1:0] rdata;
  logic            below;
  logic            hit;

  assign n_start = (MW'(item_count_i) > MW'(STORE_DEPTH)) ? CW'(STORE_DEPTH)
                                                          : CW'(item_count_i);
  assign ram_we  = cmd_i.load && (MW'(load_index_i) < MW'(STORE_DEPTH));

  sabs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (element_value_i),
    .raddr_i (mid_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // Ascending order: the prefix holds entries below the key.
  // Descending order: the prefix holds entries at or above the key.
  assign below = ($signed(rdata) < key_q);
  assign hit   = ($signed(rdata) == key_q);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    eq_d = eq_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = n_start;
      eq_d = 1'b0;
    end else if (cmd_i.step) begin
      if (asc_q ? below : !below) begin
        lo_d = mid_q + CW'(1);
        // The boundary entry in descending order is the last one in the prefix.
        if (!asc_q) begin
          eq_d = hit;
        end
      end else begin
        hi_d = mid_q;
        if (asc_q) begin
          eq_d = hit;
        end
      end
    end
    mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
    mid_d   = mid_sum[CW:1];
  end

  assign stat_o.range_open = (lo_d < hi_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= query_key_i;
      type_q <= match_type_i;
      n_q    <= n_start;
      asc_q  <= ascending_i;
    end
    if (cmd_i.start || cmd_i.step) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      mid_q <= mid_d;
      eq_q  <= eq_d;
    end
  end

  // Result decision from the partition point.
  logic signed [IXW-1:0] p_s, n_s, ix0, ix, dir;
  logic                  in0, in1;
  logic [1:0]            status;

  always_comb begin
    p_s = $signed(IXW'(lo_q));
    n_s = $signed(IXW'(n_q));
    dir = asc_q ? ONE_S : -ONE_S;
    ix0 = asc_q ? p_s : p_s - ONE_S;
    in0 = (ix0 >= 0) && (ix0 < n_s);
    ix     = ix0;
    status = ST_NONE;
    if (!in0) begin
      if (type_q == MT_LESS || type_q == MT_LESS_EQ) begin
        ix     = ix0 - dir;
        status = ST_LESS;
      end
    end else if (eq_q) begin
      case (type_q)
        MT_LESS_EQ, MT_EQUAL, MT_GREATER_EQ: status = ST_EXACT;
        MT_LESS: begin
          ix     = ix0 - dir;
          status = ST_LESS;
        end
        MT_GREATER: begin
          ix     = ix0 + dir;
          status = ST_GREATER;
        end
        default: status = ST_NONE;
      endcase
    end else begin
      case (type_q)
        MT_LESS, MT_LESS_EQ: begin
          ix     = ix0 - dir;
          status = ST_LESS;
        end
        MT_GREATER_EQ, MT_GREATER: status = ST_GREATER;
        default: status = ST_NONE;
      endcase
    end
    in1 = (ix >= 0) && (ix < n_s);
    if (!in1) begin
      status = ST_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_q <= status;
      index_q  <= (status == ST_NONE) ? 8'd0 : ix[7:0];
    end
  end

  assign match_status_o = status_q;
  assign match_index_o  = index_q;

endmodule

// File: rtl/sorted_array_bound_search.sv
// Bound search over a store of sorted, distinct signed values.
//
// One input channel carries two kinds of item: a load writes element_value at
// load_index (ignored beyond the store depth), a query searches the first
// item_count entries for query_key under one of five match types. Loads give
// no result; each query gives one result item with match_status and
// match_index on the output channel.
// A load is taken without leaving the idle state. A query runs a binary
// search with one store read per cycle: a setup step that latches the query
// and issues the first probe, probe steps whose number depends on the key,
// and a decision step, after which the next item is taken. The search loop
// runs through the registered store read port.
// The output register lets a new item be taken while a result waits. If the
// receiver stalls, the next query finishes its search and holds in the
// decision step until the waiting result has been taken.
// Reset clears the control state and sets item_count to 1 and ascending order;
// store contents are undefined until loaded. The user must let configuration
// writes go in only while the block is idle; the block does not enforce this.
module sorted_array_bound_search
  import sabs_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sabs_req_if.sink              req_i,
  sabs_rsp_if.source            rsp_o
);

  logic [8:0] item_count_q;
  logic       ascending_q;
  cmd_t       cmd;
  stat_t      stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= 9'd1;
      ascending_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ITEM_COUNT: item_count_q <= cfg_data_i[8:0];
        CFG_ASCENDING:  ascending_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid)
  );

  sabs_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .load_index_i    (req_i.load_index),
    .element_value_i (req_i.element_value),
    .query_key_i     (req_i.query_key),
    .match_type_i    (req_i.match_type),
    .item_count_i    (item_count_q),
    .ascending_i     (ascending_q),
    .match_status_o  (rsp_o.match_status),
    .match_index_o   (rsp_o.match_index)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.start, cmd.step, cmd.capture}))
    else $error("more than one datapath command at once");

  a_busy_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !req_i.ready)
    else $error("input taken while a query is in progress");

  a_capture_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> rsp_o.valid)
    else $error("captured result not presented");

  a_none_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.match_status == ST_NONE) |-> rsp_o.match_index == 8'd0)
    else $error("not-found result with nonzero index");

endmodule
